/* src/cmq_pkg.sv */
// Shared types and constants of the coalescing message queue.
// No dependencies.
`default_nettype none
package cmq_pkg;
  localparam int MSG_WORDS   = 8;
  localparam int QUEUE_DEPTH = 16;
  localparam int IDX_W       = $clog2(QUEUE_DEPTH);

  typedef logic [15:0] word_t;
  typedef logic [MSG_WORDS-1:0][15:0] msg_t;
  typedef logic [IDX_W-1:0] idx_t;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_WRITE,
    OP_MERGE,
    OP_FREE
  } op_t;

  // request held steady during a scan
  typedef struct packed {
    logic  post;
    logic  is_red;
    word_t id;
    word_t window;
  } req_t;

  // slot update issued to one cell
  typedef struct packed {
    op_t         op;
    idx_t        idx;
    word_t       dest;
    logic [31:0] order;
    msg_t        words;
  } cmd_t;

  // running search result handed from cell to cell
  typedef struct packed {
    logic        act;
    logic        mfound;
    idx_t        midx;
    logic        ffound;
    idx_t        fidx;
    logic        cfound;
    idx_t        cidx;
    logic [31:0] corder;
    logic        rfound;
    idx_t        ridx;
    logic [31:0] rorder;
  } scan_t;
endpackage
`default_nettype wire

/* src/cmq_cell.sv */
// One message slot with its share of the search chain.
// Depends on cmq_pkg.
`default_nettype none
module cmq_cell import cmq_pkg::*; #(
  parameter int IDX = 0
) (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire word_t code,
  input  wire req_t  req,
  input  wire cmd_t  cmd,
  input  wire idx_t  rd_sel,
  input  wire scan_t scan_in,
  output scan_t      scan_out,
  output msg_t       rd_words
);
  localparam idx_t MY_IDX = IDX_W'(IDX);

  logic        used;
  word_t       dest;
  logic [31:0] order;
  msg_t        words;
  scan_t       scan_next;
  logic        mine, red;

  assign mine     = used && (dest == req.id);
  assign red      = (words[0] == code);
  assign rd_words = (rd_sel == MY_IDX) ? words : '0;

  always_comb begin
    scan_next = scan_in;
    if (scan_in.act) begin
      if (req.post) begin
        if (req.is_red && mine && red && words[3] == req.window && !scan_in.mfound) begin
          scan_next.mfound = 1'b1;
          scan_next.midx   = MY_IDX;
        end
        if (!used && !scan_in.ffound) begin
          scan_next.ffound = 1'b1;
          scan_next.fidx   = MY_IDX;
        end
      end else if (mine) begin
        if (red) begin
          if (!scan_in.rfound || order < scan_in.rorder) begin
            scan_next.rfound = 1'b1;
            scan_next.ridx   = MY_IDX;
            scan_next.rorder = order;
          end
        end else if (!scan_in.cfound || order < scan_in.corder) begin
          scan_next.cfound = 1'b1;
          scan_next.cidx   = MY_IDX;
          scan_next.corder = order;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_out <= '0;
      used     <= 1'b0;
    end else begin
      scan_out <= scan_next;
      if (cmd.idx == MY_IDX) begin
        case (cmd.op)
          OP_WRITE: begin
            used  <= 1'b1;
            dest  <= cmd.dest;
            order <= cmd.order;
            words <= cmd.words;
          end
          OP_MERGE: begin
            words[7:4] <= cmd.words[7:4];
          end
          OP_FREE: begin
            used <= 1'b0;
          end
          default: begin
          end
        endcase
      end
    end
  end
endmodule
`default_nettype wire

/* src/coalescing_message_queue_top.sv */
// Top level: request control, configuration port and the row of slot cells.
// Depends on cmq_pkg and cmq_cell.
`default_nettype none
// A post that writes a slot, a failed post or a fetch that finds nothing goes from
// S_SCAN straight to S_OUT; a fetch reads and frees its slot in S_FETCH, and a merge
// passes through S_MRG_A and S_MRG_B first. The search token walks the row of cells
// one slot per cycle, and S_OUT loads the result beat. A buffer shorter than eight
// words skips the scan and goes straight to S_OUT. A result beat stalled by m_tready
// holds off the next load. One request is in flight at a time.
module coalescing_message_queue_top import cmq_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  input  wire logic [151:0] s_tdata,  // app_id, buffer_words, msg_type, msg_word1,
                                      // msg_word2, msg_window, rect_x, rect_y, rect_w, rect_h
  input  wire logic         s_tuser,  // mode
  output logic              m_tvalid,
  input  wire logic         m_tready,
  output logic [127:0]      m_tdata,  // out_type, out_word1, out_word2, out_window,
                                      // out_x, out_y, out_w, out_h
  output logic [1:0]        m_tuser,  // ok, merged
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [2:0]   paddr,
  input  wire logic [31:0]  pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);
  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_FETCH, S_MRG_A, S_MRG_B, S_OUT
  } state_t;

  state_t      state;
  word_t       code;
  req_t        req;
  msg_t        req_words;
  scan_t       inj;
  cmd_t        cmd;
  idx_t        sel;
  logic [31:0] order_counter;
  logic        res_ok, res_merged;
  msg_t        res_words;
  word_t       x0, y0, x1, y1;

  scan_t       chain [QUEUE_DEPTH+1];
  msg_t        rd_all [QUEUE_DEPTH];
  msg_t        rd_words;
  scan_t       tok;
  word_t       tx1, ty1, nx1, ny1, mw, mh;

  assign pready   = 1'b1;
  assign prdata   = {16'd0, code};
  assign s_tready = (state == S_IDLE);
  assign chain[0] = inj;
  assign tok      = chain[QUEUE_DEPTH];

  for (genvar k = 0; k < QUEUE_DEPTH; k++) begin : g_cell
    cmq_cell #(.IDX(k)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .code     (code),
      .req      (req),
      .cmd      (cmd),
      .rd_sel   (sel),
      .scan_in  (chain[k]),
      .scan_out (chain[k+1]),
      .rd_words (rd_all[k])
    );
  end

  always_comb begin
    rd_words = '0;
    for (int k = 0; k < QUEUE_DEPTH; k++) rd_words = rd_words | rd_all[k];
  end

  assign tx1 = rd_words[4] + rd_words[6] - 16'd1;
  assign ty1 = rd_words[5] + rd_words[7] - 16'd1;
  assign nx1 = req_words[4] + req_words[6] - 16'd1;
  assign ny1 = req_words[5] + req_words[7] - 16'd1;
  assign mw  = x1 - x0 + 16'd1;
  assign mh  = y1 - y0 + 16'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      code          <= 16'd20;
      inj           <= '0;
      cmd.op        <= OP_NONE;
      order_counter <= '0;
      m_tvalid      <= 1'b0;
    end else begin
      inj.act <= 1'b0;
      cmd.op  <= OP_NONE;
      if (psel && penable && pwrite && !paddr[2]) code <= pwdata[15:0];
      if (m_tvalid && m_tready) m_tvalid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            req.post   <= !s_tuser;
            req.id     <= s_tdata[15:0];
            req.window <= s_tdata[87:72];
            req.is_red <= (s_tdata[39:24] == code);
            req_words  <= s_tdata[151:24];
            res_ok     <= 1'b0;
            res_merged <= 1'b0;
            res_words  <= '0;
            if (s_tdata[23:16] < 8'(MSG_WORDS)) begin
              state <= S_OUT;
            end else begin
              inj     <= '0;
              inj.act <= 1'b1;
              state   <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (tok.act) begin
            state <= S_OUT;
            if (req.post) begin
              if (req.is_red && tok.mfound) begin
                sel   <= tok.midx;
                state <= S_MRG_A;
              end else if (tok.ffound) begin
                cmd.op        <= OP_WRITE;
                cmd.idx       <= tok.fidx;
                cmd.dest      <= req.id;
                cmd.order     <= order_counter;
                cmd.words     <= req_words;
                order_counter <= order_counter + 32'd1;
                res_ok        <= 1'b1;
              end
            end else if (tok.cfound) begin
              sel   <= tok.cidx;
              state <= S_FETCH;
            end else if (tok.rfound) begin
              sel   <= tok.ridx;
              state <= S_FETCH;
            end
          end
        end
        S_FETCH: begin
          res_ok    <= 1'b1;
          res_words <= rd_words;
          cmd.op    <= OP_FREE;
          cmd.idx   <= sel;
          state     <= S_OUT;
        end
        S_MRG_A: begin
          x0 <= ($signed(rd_words[4]) < $signed(req_words[4])) ? rd_words[4] : req_words[4];
          y0 <= ($signed(rd_words[5]) < $signed(req_words[5])) ? rd_words[5] : req_words[5];
          x1 <= ($signed(tx1) > $signed(nx1)) ? tx1 : nx1;
          y1 <= ($signed(ty1) > $signed(ny1)) ? ty1 : ny1;
          state <= S_MRG_B;
        end
        S_MRG_B: begin
          cmd.op       <= OP_MERGE;
          cmd.idx      <= sel;
          cmd.words[4] <= x0;
          cmd.words[5] <= y0;
          cmd.words[6] <= mw;
          cmd.words[7] <= mh;
          res_ok       <= 1'b1;
          res_merged   <= 1'b1;
          state        <= S_OUT;
        end
        S_OUT: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= res_words;
            m_tuser  <= {res_merged, res_ok};
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

/* src/cmq_checker.sv */
// Port-level checks of the coalescing message queue, bound to the top level.
// Depends on coalescing_message_queue_top.
`default_nettype none
module cmq_checker (
  input wire logic         clk,
  input wire logic         rst,
  input wire logic         m_tvalid,
  input wire logic         m_tready,
  input wire logic [127:0] m_tdata,
  input wire logic [1:0]   m_tuser
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result beat dropped or changed while stalled");
  a_rst: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result beat after reset");
  a_merge_ok: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[1] |-> m_tuser[0] && m_tdata == '0)
    else $error("merge beat without ok or with data");
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[0] |-> m_tdata == '0 && !m_tuser[1])
    else $error("failed beat carries data");
endmodule

bind coalescing_message_queue_top cmq_checker u_cmq_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
`default_nettype wire

/* tb/cmq_checker.sv */
// Checker for the coalescing message queue: watches config writes and both streams,
// predicts each result from its own slot table and compares beat by beat. Depends on cmq_pkg.
module cmq_scoreboard import cmq_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  input  wire logic         s_tready,
  input  wire logic [151:0] s_tdata,
  input  wire logic         s_tuser,
  input  wire logic         m_tvalid,
  input  wire logic         m_tready,
  input  wire logic [127:0] m_tdata,
  input  wire logic [1:0]   m_tuser,
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [2:0]   paddr,
  input  wire logic [31:0]  pwdata,
  input  wire logic         pready,
  output int                errors,
  output int                pending
);
  timeunit 1ns;
  timeprecision 1ps;
  localparam int DEPTH = 16;
  localparam logic [2:0] REG_REDRAW = 3'd0;

  typedef struct packed {
    logic [1:0]   flags;
    logic [127:0] words;
  } reply_t;

  logic [15:0] redraw;
  logic        used [DEPTH];
  logic [15:0] dest [DEPTH];
  logic [31:0] seqno [DEPTH];
  logic [15:0] body [DEPTH][8];
  logic [31:0] next_seq;
  reply_t      replies[$];

  function automatic logic signed [15:0] smin(logic signed [15:0] a, logic signed [15:0] b);
    return a < b ? a : b;
  endfunction
  function automatic logic signed [15:0] smax(logic signed [15:0] a, logic signed [15:0] b);
    return a > b ? a : b;
  endfunction

  function automatic reply_t queue_op(logic fetch, logic [151:0] d);
    reply_t r;
    logic [15:0] id, w[8], x1, y1, nx1, ny1, x0, y0;
    int ctl, red, pick;
    r = '0;
    id = d[15:0];
    for (int k = 0; k < 8; k++) w[k] = d[24+16*k +: 16];
    if (d[23:16] < 8) return r;
    if (!fetch) begin
      if (w[0] == redraw) begin
        for (int i = 0; i < DEPTH; i++) begin
          if (used[i] && dest[i] == id && body[i][0] == redraw && body[i][3] == w[3]) begin
            x1 = body[i][4] + body[i][6] - 16'd1;
            y1 = body[i][5] + body[i][7] - 16'd1;
            nx1 = w[4] + w[6] - 16'd1;
            ny1 = w[5] + w[7] - 16'd1;
            x0 = smin(body[i][4], w[4]);
            y0 = smin(body[i][5], w[5]);
            x1 = smax(x1, nx1);
            y1 = smax(y1, ny1);
            body[i][4] = x0;
            body[i][5] = y0;
            body[i][6] = x1 - x0 + 16'd1;
            body[i][7] = y1 - y0 + 16'd1;
            r.flags = 2'b11;
            return r;
          end
        end
      end
      for (int i = 0; i < DEPTH; i++) begin
        if (!used[i]) begin
          used[i] = 1'b1;
          dest[i] = id;
          seqno[i] = next_seq;
          next_seq++;
          for (int k = 0; k < 8; k++) body[i][k] = w[k];
          r.flags = 2'b01;
          return r;
        end
      end
      return r;
    end
    ctl = -1;
    red = -1;
    for (int i = 0; i < DEPTH; i++) begin
      if (used[i] && dest[i] == id) begin
        if (body[i][0] == redraw) begin
          if (red < 0 || seqno[i] < seqno[red]) red = i;
        end else if (ctl < 0 || seqno[i] < seqno[ctl]) begin
          ctl = i;
        end
      end
    end
    pick = ctl >= 0 ? ctl : red;
    if (pick < 0) return r;
    r.flags = 2'b01;
    for (int k = 0; k < 8; k++) r.words[16*k +: 16] = body[pick][k];
    used[pick] = 1'b0;
    return r;
  endfunction

  assign pending = replies.size();

  always @(posedge clk) begin
    reply_t e;
    if (rst) begin
      redraw <= 16'd20;
      next_seq <= '0;
      for (int i = 0; i < DEPTH; i++) used[i] <= 1'b0;
      replies.delete();
      errors <= 0;
    end else begin
      if (psel && penable && pwrite && pready && paddr == REG_REDRAW) redraw <= pwdata[15:0];
      if (s_tvalid && s_tready) replies.push_back(queue_op(s_tuser, s_tdata));
      if (m_tvalid && m_tready) begin
        if (replies.size() == 0) begin
          if (errors < 10) $display("unexpected result beat %h/%h", m_tuser, m_tdata);
          errors <= errors + 1;
        end else begin
          e = replies.pop_front();
          if (e.flags !== m_tuser || e.words !== m_tdata) begin
            if (errors < 10)
              $display("mismatch: exp ok/merged %b words %h, got %b words %h",
                       e.flags, e.words, m_tuser, m_tdata);
            errors <= errors + 1;
          end
        end
      end
    end
  end
endmodule

/* tb/tb.sv */
// Testbench top for coalescing_message_queue_top: reset, APB register writes and
// stream stimulus with random idling; verdict from cmq_scoreboard. Depends on cmq_pkg.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import cmq_pkg::*;
  localparam logic [2:0] REG_REDRAW = 3'd0;

  logic clk = 0, rst = 1;
  logic s_tvalid = 0, s_tuser = 0, m_tready = 0;
  logic [151:0] s_tdata = '0;
  logic s_tready, m_tvalid, pready;
  logic [127:0] m_tdata;
  logic [1:0] m_tuser;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0, prdata;
  int errors, pending, cycles = 0;
  int s_idle = 0, m_idle = 0;
  logic [15:0] code = 16'd20;
  logic [15:0] ids[4], wins[3];

  always #5 clk = ~clk;

  coalescing_message_queue_top uut (.*);
  cmq_scoreboard chk (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("coalescing_message_queue_top test failed");
      $finish;
    end
  end

  always @(negedge clk) m_tready <= ($urandom_range(99) >= m_idle);

  task automatic write_code(logic [15:0] v);
    @(negedge clk);
    psel <= 1; pwrite <= 1; paddr <= REG_REDRAW; pwdata <= {16'(v), v};
    @(negedge clk);
    penable <= 1;
    @(negedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    code = v;
  endtask

  task automatic drain();
    while (pending != 0) @(negedge clk);
    repeat (30) @(negedge clk);
  endtask

  task automatic send(logic fetch, logic [15:0] id, logic [7:0] len, logic [15:0] w[8]);
    @(negedge clk);
    while ($urandom_range(99) < s_idle) @(negedge clk);
    s_tvalid <= 1;
    s_tuser <= fetch;
    s_tdata <= {w[7], w[6], w[5], w[4], w[3], w[2], w[1], w[0], len, id};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
    s_tvalid <= 0;
  endtask

  task automatic rand_item(bit noise);
    logic [15:0] w[8];
    logic fetch;
    logic [15:0] id;
    logic [7:0] len;
    for (int k = 0; k < 8; k++) w[k] = 16'($urandom);
    fetch = $urandom_range(99) < 45;
    id = noise ? 16'($urandom) : ids[$urandom_range(3)];
    len = ($urandom_range(19) == 0) ? 8'($urandom_range(7)) : 8'($urandom_range(255, 8));
    if (!noise) begin
      if ($urandom_range(1)) w[0] = code;
      w[3] = wins[$urandom_range(2)];
      if ($urandom_range(1)) begin
        w[4] = 16'($urandom_range(200) - 100); w[5] = 16'($urandom_range(200) - 100);
        w[6] = 16'($urandom_range(60)); w[7] = 16'($urandom_range(60));
      end
    end
    send(fetch, id, len, w);
  endtask

  initial begin
    logic [15:0] w[8];
    ids = '{16'h0001, 16'h8000, 16'h7fff, 16'hffff};
    wins = '{16'h0000, 16'h1234, 16'hffff};
    repeat (8) @(posedge clk);
    @(negedge clk) rst <= 0;
    // directed: short buffers, redraw merges, full table, fetch priority, empty fetch
    for (int k = 0; k < 8; k++) w[k] = 16'hffff;
    send(0, 16'h0001, 8'd7, w);
    send(1, 16'h0001, 8'd0, w);
    w = '{16'd20, 16'h0, 16'h0, 16'h1234, 16'h8000, 16'h7fff, 16'h7fff, 16'h8000};
    send(0, 16'h0001, 8'd255, w);
    w = '{16'd20, 16'hffff, 16'hffff, 16'h1234, 16'h7fff, 16'h8000, 16'h0001, 16'hffff};
    send(0, 16'h0001, 8'd8, w);
    w = '{16'h0005, 16'h5555, 16'haaaa, 16'h1234, 16'h0, 16'h0, 16'h0, 16'h0};
    for (int i = 0; i < 16; i++) send(0, 16'h0001, 8'd8, w);
    send(1, 16'h0001, 8'd8, w);
    send(1, 16'h0001, 8'd8, w);
    send(1, 16'h8000, 8'd8, w);
    drain();
    for (int ph = 0; ph < 3; ph++) begin
      s_idle = ph == 0 ? 34 : ph == 1 ? 77 : 0;
      m_idle = ph == 0 ? 77 : ph == 1 ? 34 : 0;
      write_code(ph == 0 ? 16'h8000 : ph == 1 ? 16'h7fff : 16'($urandom));
      for (int n = 0; n < 340; n++) begin
        rand_item($urandom_range(9) == 0);
        if (n == 170) drain();
      end
      drain();
    end
    write_code(16'd20);
    drain();
    if (errors == 0 && pending == 0) begin
      $display("coalescing_message_queue_top test passed");
    end else begin
      $display("coalescing_message_queue_top test failed");
    end
    $finish;
  end
endmodule
